// ===== sv/mi3_pkg.sv =====
// ============================================================================
// mi3_pkg
// Shared widths, types and the cofactor index table for the 3x3 inverse core.
// ============================================================================
package mi3_pkg;

    // Element and intermediate widths.
    localparam int ElemW  = 32;          // Q16.16 element
    localparam int ProdW  = 64;          // product of two elements
    localparam int CofW   = 65;          // exact cofactor, signed
    localparam int MagW   = 64;          // cofactor magnitude
    localparam int DetW   = 98;          // exact determinant, signed
    localparam int DmagW  = 97;          // determinant magnitude
    localparam int QuoW   = 33;          // quotient bits 32 down to 0
    localparam int DivN   = 33;          // one division step per stage
    localparam int FrontN = 7;           // stages before the divider
    localparam int StageN = FrontN + DivN + 1;
    localparam int EpsW   = 31;

    typedef logic signed [ElemW-1:0] t_elem;
    typedef t_elem [8:0]              t_mat;
    typedef logic [3:0]               t_idx;

    // Each adjugate entry is A*B - C*D over these column-major indices.
    localparam t_idx COF_IDX [0:8][0:3] = '{
        '{4'd8, 4'd4, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd8, 4'd1},
        '{4'd5, 4'd1, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd8, 4'd3},
        '{4'd8, 4'd0, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd5, 4'd0},
        '{4'd7, 4'd3, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd7, 4'd0},
        '{4'd4, 4'd0, 4'd1, 4'd3}
    };

endpackage

// ===== sv/matrix3_inverse_core.sv =====
// ============================================================================
// matrix3_inverse_core
// Pipelined 3x3 matrix inverse by adjugate over determinant, Q16.16.
// ============================================================================
//
// Channel     Direction  Contents
// s_axis      in         tdata: nine Q16.16 elements, column-major
// m_axis      out        tdata: nine result elements; tuser: singular flag
// cfg         in         singular_epsilon write
//
// One request can be taken every cycle while m_axis accepts results, because every
// stage is pipelined; the 33-stage restoring divider, one quotient bit per stage for
// all nine lanes, accounts for most of the latency.
// Each stage holds its own valid bit and advances when the next stage is free,
// so a stall at m_axis fills bubbles before s_axis_tready falls.
// Reset is synchronous, clears every valid bit and sets epsilon to one LSB (2^-16).
//
module matrix3_inverse_core
    import mi3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2
    input  logic [287:0]       s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_c0_r0, out_c0_r1, ..., out_c2_r2
    output logic [287:0]       m_axis_tdata,
    // singular
    output logic               m_axis_tuser,
    input  logic               i_cfg_we,
    input  logic [EpsW-1:0]    i_cfg_wdata
);

    // Epsilon register.
    logic [EpsW-1:0] r_eps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EpsW'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Valid bits and per-stage advance enables.
    logic [StageN-1:0] r_vld;
    logic [StageN-1:0] ce;
    logic [StageN-1:0] vin;

    always_comb begin
        ce[StageN-1] = !r_vld[StageN-1] || m_axis_tready;
        for (int k = StageN - 2; k >= 0; k--) begin
            ce[k] = !r_vld[k] || ce[k+1];
        end
        vin[0] = s_axis_tvalid;
        for (int k = 1; k < StageN; k++) begin
            vin[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < StageN; k++) begin
                if (ce[k]) r_vld[k] <= vin[k];
            end
        end
    end

    assign s_axis_tready = ce[0];

    // Stage 1: the eighteen element products.
    t_mat in_x;
    assign in_x = t_mat'(s_axis_tdata);

    logic signed [ProdW-1:0] n1_p  [0:17];
    logic signed [ProdW-1:0] r1_p  [0:17];
    t_mat                    r1_x;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n1_p[2*i]   = ProdW'(in_x[COF_IDX[i][0]]) * ProdW'(in_x[COF_IDX[i][1]]);
            n1_p[2*i+1] = ProdW'(in_x[COF_IDX[i][2]]) * ProdW'(in_x[COF_IDX[i][3]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r1_p <= n1_p;
            r1_x <= in_x;
        end
    end

    // Stage 2: exact adjugate entries.
    logic signed [CofW-1:0] r2_a [0:8];
    t_mat                   r2_x;

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            for (int i = 0; i < 9; i++) begin
                r2_a[i] <= CofW'(r1_p[2*i]) - CofW'(r1_p[2*i+1]);
            end
            r2_x <= r1_x;
        end
    end

    // Stage 3: determinant partial products, cofactor split at bit 32.
    logic signed [CofW-1:0] n3_lo [0:2];
    logic signed [CofW-1:0] n3_hi [0:2];
    logic signed [CofW-1:0] r3_lo [0:2];
    logic signed [CofW-1:0] r3_hi [0:2];
    logic signed [CofW-1:0] r3_a  [0:8];
    t_mat                   r3_x;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n3_lo[k] = CofW'(r2_x[k]) * $signed({33'd0, r2_a[3*k][31:0]});
            n3_hi[k] = CofW'(r2_x[k]) * CofW'($signed(r2_a[3*k][CofW-1:32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[2]) begin
            r3_lo <= n3_lo;
            r3_hi <= n3_hi;
            r3_a  <= r2_a;
            r3_x  <= r2_x;
        end
    end

    // Stage 4: the three expansion terms.
    logic signed [DetW-1:0] r4_t [0:2];
    logic signed [CofW-1:0] r4_a [0:8];
    t_mat                   r4_x;

    always_ff @(posedge i_clk) begin
        if (ce[3]) begin
            for (int k = 0; k < 3; k++) begin
                r4_t[k] <= (DetW'(r3_hi[k]) <<< 32) + DetW'(r3_lo[k]);
            end
            r4_a <= r3_a;
            r4_x <= r3_x;
        end
    end

    // Stage 5: determinant.
    logic signed [DetW-1:0] r5_det;
    logic signed [CofW-1:0] r5_a [0:8];
    t_mat                   r5_x;

    always_ff @(posedge i_clk) begin
        if (ce[4]) begin
            r5_det <= r4_t[0] + r4_t[1] + r4_t[2];
            r5_a   <= r4_a;
            r5_x   <= r4_x;
        end
    end

    // Stage 6: determinant magnitude and the singular test.
    logic [DetW-1:0]        n6_abs;
    logic [DmagW-1:0]       r6_d;
    logic                   r6_dneg;
    logic                   r6_sing;
    logic signed [CofW-1:0] r6_a [0:8];
    t_mat                   r6_x;

    assign n6_abs = r5_det[DetW-1] ? DetW'(-r5_det) : DetW'(r5_det);

    always_ff @(posedge i_clk) begin
        if (ce[5]) begin
            r6_d    <= n6_abs[DmagW-1:0];
            r6_dneg <= r5_det[DetW-1];
            r6_sing <= n6_abs[DmagW-1:0] <= DmagW'({r_eps, 32'd0});
            r6_a    <= r5_a;
            r6_x    <= r5_x;
        end
    end

    // Stage 7: cofactor magnitudes, result signs and the overflow check.
    logic [CofW-1:0]  n7_abs [0:8];
    logic [DmagW-1:0] r7_rem [0:8];
    logic [8:0]       r7_neg;
    logic [8:0]       r7_ovf;
    logic [DmagW-1:0] r7_d;
    logic             r7_sing;
    t_mat             r7_x;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n7_abs[i] = r6_a[i][CofW-1] ? CofW'(-r6_a[i]) : CofW'(r6_a[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[6]) begin
            for (int i = 0; i < 9; i++) begin
                r7_rem[i] <= DmagW'(n7_abs[i][MagW-1:0]);
                r7_neg[i] <= r6_a[i][CofW-1] ^ r6_dneg;
                // A quotient of 2^33 or more always saturates.
                r7_ovf[i] <= DetW'(n7_abs[i][MagW-1:0]) >= {r6_d, 1'b0};
            end
            r7_d    <= r6_d;
            r7_sing <= r6_sing;
            r7_x    <= r6_x;
        end
    end

    // Divider: one restoring step per stage, nine lanes side by side.
    logic [DmagW-1:0] r_dv_rem  [0:DivN-1][0:8];
    logic [QuoW-1:0]  r_dv_quo  [0:DivN-1][0:8];
    logic [8:0]       r_dv_neg  [0:DivN-1];
    logic [8:0]       r_dv_ovf  [0:DivN-1];
    logic [DmagW-1:0] r_dv_d    [0:DivN-1];
    logic             r_dv_sing [0:DivN-1];
    t_mat             r_dv_x    [0:DivN-1];

    for (genvar j = 0; j < DivN; j++) begin : g_div
        logic [DmagW-1:0] p_rem [0:8];
        logic [QuoW-1:0]  p_quo [0:8];
        logic [8:0]       p_neg;
        logic [8:0]       p_ovf;
        logic [DmagW-1:0] p_d;
        logic             p_sing;
        t_mat             p_x;
        logic [DetW-1:0]  n_sh  [0:8];
        logic [8:0]       n_ge;

        if (j == 0) begin : g_first
            always_comb begin
                p_rem  = r7_rem;
                p_quo  = '{default: '0};
                p_neg  = r7_neg;
                p_ovf  = r7_ovf;
                p_d    = r7_d;
                p_sing = r7_sing;
                p_x    = r7_x;
                for (int i = 0; i < 9; i++) begin
                    n_sh[i] = DetW'(p_rem[i]);
                end
            end
        end else begin : g_next
            always_comb begin
                p_rem  = r_dv_rem[j-1];
                p_quo  = r_dv_quo[j-1];
                p_neg  = r_dv_neg[j-1];
                p_ovf  = r_dv_ovf[j-1];
                p_d    = r_dv_d[j-1];
                p_sing = r_dv_sing[j-1];
                p_x    = r_dv_x[j-1];
                for (int i = 0; i < 9; i++) begin
                    n_sh[i] = {p_rem[i], 1'b0};
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 9; i++) begin
                n_ge[i] = n_sh[i] >= DetW'(p_d);
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce[FrontN + j]) begin
                for (int i = 0; i < 9; i++) begin
                    r_dv_rem[j][i] <= n_ge[i] ? DmagW'(n_sh[i] - DetW'(p_d))
                                              : DmagW'(n_sh[i]);
                    r_dv_quo[j][i] <= {p_quo[i][QuoW-2:0], n_ge[i]};
                end
                r_dv_neg[j]  <= p_neg;
                r_dv_ovf[j]  <= p_ovf;
                r_dv_d[j]    <= p_d;
                r_dv_sing[j] <= p_sing;
                r_dv_x[j]    <= p_x;
            end
        end
    end

    // Output stage: round half away from zero, saturate, apply sign; a singular input is passed through.
    logic [QuoW:0]    n_q   [0:8];
    logic [ElemW-1:0] n_lim [0:8];
    logic [ElemW-1:0] n_mag [0:8];
    t_mat             n_res;
    t_mat             r_o_data;
    logic             r_o_sing;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_q[i]   = (QuoW+1)'(r_dv_quo[DivN-1][i])
                     + (QuoW+1)'({r_dv_rem[DivN-1][i], 1'b0} >= DetW'(r_dv_d[DivN-1]));
            n_lim[i] = r_dv_neg[DivN-1][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            n_mag[i] = (r_dv_ovf[DivN-1][i] || n_q[i] > (QuoW+1)'(n_lim[i]))
                       ? n_lim[i] : n_q[i][ElemW-1:0];
            n_res[i] = r_dv_sing[DivN-1] ? r_dv_x[DivN-1][i]
                     : (r_dv_neg[DivN-1][i] ? t_elem'(-n_mag[i]) : t_elem'(n_mag[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[StageN-1]) begin
            r_o_data <= n_res;
            r_o_sing <= r_dv_sing[DivN-1];
        end
    end

    assign m_axis_tvalid = r_vld[StageN-1];
    assign m_axis_tdata  = 288'(r_o_data);
    assign m_axis_tuser  = r_o_sing;

endmodule
